// File: src/assert_macros.svh
// Assertion helpers; clk and rst_n are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/fsnf_pkg.sv
package fsnf_pkg;

  localparam int NAME_CHARS = 8;
  localparam int EXT_CHARS  = 3;
  localparam int CHAR_W     = 8;
  localparam int LEN_W      = 4;
  localparam int CAP_W      = 8;
  localparam int NAME_W     = 64;
  localparam int EXT_W      = 24;
  localparam int NAME_IW    = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;
  localparam int EXT_IW     = (EXT_CHARS > 1) ? $clog2(EXT_CHARS) : 1;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'h00;
  localparam logic [CHAR_W-1:0] DOT_CHAR   = 8'h2e;

  typedef struct packed {
    logic is_space;
    logic is_zero;
    logic tail_space;
  } lane_flags_t;

  typedef struct packed {
    logic [NAME_CHARS-1:0][CHAR_W-1:0] name;
    logic [EXT_CHARS-1:0][CHAR_W-1:0]  ext;
    logic [LEN_W-1:0]                  nlen;
    logic [LEN_W-1:0]                  n_emit;
    logic [LEN_W-1:0]                  total;
    logic                              err;
  } job_t;

endpackage

// File: src/fsnf_lane.sv
module fsnf_lane (
  input  logic [fsnf_pkg::CHAR_W-1:0] ch,
  input  logic                        tail_in,
  output fsnf_pkg::lane_flags_t       flags
);

  always_comb begin
    flags.is_space   = (ch == fsnf_pkg::SPACE_CHAR);
    flags.is_zero    = (ch == fsnf_pkg::NUL_CHAR);
    flags.tail_space = flags.is_space & tail_in;
  end

endmodule

// File: src/fsnf_merge.sv
`include "assert_macros.svh"

module fsnf_merge (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                accept,
  input  logic [fsnf_pkg::NAME_CHARS-1:0][fsnf_pkg::CHAR_W-1:0] name,
  input  logic [fsnf_pkg::EXT_CHARS-1:0][fsnf_pkg::CHAR_W-1:0]  ext,
  input  logic [fsnf_pkg::CAP_W-1:0]                          cap,
  input  fsnf_pkg::lane_flags_t [fsnf_pkg::NAME_CHARS-1:0]    name_flags,
  input  fsnf_pkg::lane_flags_t [fsnf_pkg::EXT_CHARS-1:0]     ext_flags,
  input  logic                                                take,
  output logic                                                pend_valid,
  output fsnf_pkg::job_t                                      pend_job
);

  logic [fsnf_pkg::LEN_W-1:0] nlen;
  logic [fsnf_pkg::LEN_W-1:0] elen;
  logic [fsnf_pkg::LEN_W-1:0] eemit;
  logic [fsnf_pkg::LEN_W-1:0] total;
  logic [fsnf_pkg::LEN_W-1:0] n_emit;
  logic                       pend_valid_r;
  logic                       pend_valid_nxt;
  fsnf_pkg::job_t             pend_job_r;

  always_comb begin
    nlen  = fsnf_pkg::LEN_W'(fsnf_pkg::NAME_CHARS);
    elen  = fsnf_pkg::LEN_W'(fsnf_pkg::EXT_CHARS);
    eemit = fsnf_pkg::LEN_W'(fsnf_pkg::EXT_CHARS);
    for (int k = fsnf_pkg::NAME_CHARS - 1; k >= 0; k--) begin
      if (name_flags[k].is_zero || name_flags[k].tail_space) begin
        nlen = fsnf_pkg::LEN_W'(k);
      end
    end
    for (int k = fsnf_pkg::EXT_CHARS - 1; k >= 0; k--) begin
      if (ext_flags[k].is_space) begin
        elen = fsnf_pkg::LEN_W'(k);
      end
      if (ext_flags[k].is_space || ext_flags[k].is_zero) begin
        eemit = fsnf_pkg::LEN_W'(k);
      end
    end
    total  = nlen + elen + ((elen != '0) ? fsnf_pkg::LEN_W'(1) : '0);
    n_emit = nlen + ((elen != '0) ? (eemit + fsnf_pkg::LEN_W'(1)) : '0);
  end

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    if (accept) begin
      pend_valid_nxt = 1'b1;
    end else if (take) begin
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_job_r.name   <= name;
      pend_job_r.ext    <= ext;
      pend_job_r.nlen   <= nlen;
      pend_job_r.n_emit <= n_emit;
      pend_job_r.total  <= total;
      pend_job_r.err    <= ({{(fsnf_pkg::CAP_W - fsnf_pkg::LEN_W){1'b0}}, total} >= cap);
    end
  end

  assign pend_valid = pend_valid_r;
  assign pend_job   = pend_job_r;

  `ASSERT_NEXT(a_pend_holds, pend_valid_r && !take, pend_valid_r)
  `ASSERT_NEXT(a_accept_fills, accept, pend_valid_r)
  `ASSERT_IMPLIES(a_no_accept_when_full, pend_valid_r && !take, !accept)

endmodule

// File: src/fsnf_emit.sv
`include "assert_macros.svh"

module fsnf_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pend_valid,
  input  fsnf_pkg::job_t              pend_job,
  output logic                        take,
  output logic                        out_valid,
  output logic [fsnf_pkg::CHAR_W-1:0] out_char,
  output logic [fsnf_pkg::LEN_W-1:0]  out_name_length,
  output logic                        out_status,
  output logic                        out_last
);

  fsnf_pkg::job_t             job_r;
  logic                       act_r;
  logic                       act_nxt;
  logic [fsnf_pkg::LEN_W-1:0] idx_r;
  logic [fsnf_pkg::LEN_W-1:0] idx_nxt;
  logic [fsnf_pkg::LEN_W-1:0] ext_off;
  logic [fsnf_pkg::CHAR_W-1:0] ch;
  logic                       last_now;
  logic                       out_valid_r;
  logic [fsnf_pkg::CHAR_W-1:0] out_char_r;
  logic [fsnf_pkg::LEN_W-1:0] out_len_r;
  logic                       out_status_r;
  logic                       out_last_r;

  always_comb begin
    ext_off  = idx_r - job_r.nlen - fsnf_pkg::LEN_W'(1);
    last_now = job_r.err || (idx_r == job_r.n_emit);
    priority if (job_r.err || idx_r == job_r.n_emit) begin
      ch = fsnf_pkg::NUL_CHAR;
    end else if (idx_r < job_r.nlen) begin
      ch = job_r.name[idx_r[fsnf_pkg::NAME_IW-1:0]];
    end else if (idx_r == job_r.nlen) begin
      ch = fsnf_pkg::DOT_CHAR;
    end else begin
      ch = job_r.ext[ext_off[fsnf_pkg::EXT_IW-1:0]];
    end
  end

  assign take = !act_r || last_now;

  always_comb begin
    act_nxt = act_r;
    idx_nxt = idx_r;
    if (take) begin
      act_nxt = pend_valid;
      idx_nxt = '0;
    end else begin
      idx_nxt = idx_r + fsnf_pkg::LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take && pend_valid) begin
      job_r <= pend_job;
    end
    out_char_r   <= ch;
    out_len_r    <= job_r.total;
    out_status_r <= job_r.err;
    out_last_r   <= last_now;
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_name_length = out_len_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

  `ASSERT_IMPLIES(a_idx_bound, act_r, idx_r <= job_r.n_emit)
  `ASSERT_IMPLIES(a_err_single, out_valid_r && out_status_r, out_last_r)
  `ASSERT_NEXT(a_run_continues, act_r && !last_now, act_r && idx_r == $past(idx_r) + 1'b1)

endmodule

// File: src/fat_short_name_formatter.sv
// An accepted name moves through the pending, job and output registers in that order.
// Throughput: one result per cycle while names wait; each name gives its characters
//   and a NUL, at most 13 results, via the single emitter; an error gives a single NUL.
// A second name may be accepted while the current one is still being emitted.
// Reset (synchronous, rst_n low) drops any pending and in-flight names.
// out_valid strobes each result for one cycle; the receiver cannot stall.
module fat_short_name_formatter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [fsnf_pkg::NAME_W-1:0]   in_name_chars,
  input  logic [fsnf_pkg::EXT_W-1:0]    in_ext_chars,
  input  logic [fsnf_pkg::CAP_W-1:0]    in_buffer_size,
  output logic                          out_valid,
  output logic [fsnf_pkg::CHAR_W-1:0]   out_char,
  output logic [fsnf_pkg::LEN_W-1:0]    out_name_length,
  output logic                          out_status,
  output logic                          out_last
);

  logic [fsnf_pkg::NAME_CHARS-1:0][fsnf_pkg::CHAR_W-1:0] name;
  logic [fsnf_pkg::EXT_CHARS-1:0][fsnf_pkg::CHAR_W-1:0]  ext;
  fsnf_pkg::lane_flags_t [fsnf_pkg::NAME_CHARS-1:0]      name_flags;
  fsnf_pkg::lane_flags_t [fsnf_pkg::EXT_CHARS-1:0]       ext_flags;
  logic [fsnf_pkg::NAME_CHARS:0]                         name_tail;
  logic                                                  accept;
  logic                                                  take;
  logic                                                  pend_valid;
  fsnf_pkg::job_t                                        pend_job;

  assign busy   = pend_valid && !take;
  assign accept = start && !busy;
  assign name_tail[fsnf_pkg::NAME_CHARS] = 1'b1;

  for (genvar k = 0; k < fsnf_pkg::NAME_CHARS; k++) begin : g_name
    assign name[k]      = in_name_chars[k*fsnf_pkg::CHAR_W +: fsnf_pkg::CHAR_W];
    assign name_tail[k] = name_flags[k].tail_space;
    fsnf_lane u_lane (
      .ch      (name[k]),
      .tail_in (name_tail[k+1]),
      .flags   (name_flags[k])
    );
  end

  for (genvar k = 0; k < fsnf_pkg::EXT_CHARS; k++) begin : g_ext
    assign ext[k] = in_ext_chars[k*fsnf_pkg::CHAR_W +: fsnf_pkg::CHAR_W];
    fsnf_lane u_lane (
      .ch      (ext[k]),
      .tail_in (1'b0),
      .flags   (ext_flags[k])
    );
  end

  fsnf_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .name       (name),
    .ext        (ext),
    .cap        (in_buffer_size),
    .name_flags (name_flags),
    .ext_flags  (ext_flags),
    .take       (take),
    .pend_valid (pend_valid),
    .pend_job   (pend_job)
  );

  fsnf_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .pend_valid      (pend_valid),
    .pend_job        (pend_job),
    .take            (take),
    .out_valid       (out_valid),
    .out_char        (out_char),
    .out_name_length (out_name_length),
    .out_status      (out_status),
    .out_last        (out_last)
  );

endmodule

// File: verif/fsnf_tb_pkg.sv
`timescale 1ns / 1ps

package fsnf_tb_pkg;

  import fsnf_pkg::*;

  localparam logic ST_OK    = 1'b0;
  localparam logic ST_SHORT = 1'b1;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  len;
    logic              status;
    logic              last;
  } name_beat_t;

  class dotted_name_board;
    name_beat_t pending_beats[$];
    int         mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void note_name(logic [NAME_W-1:0] nm, logic [EXT_W-1:0] ex,
                            logic [CAP_W-1:0] cap);
      int         cut;
      int         nlen;
      int         elen;
      int         total;
      int         k;
      name_beat_t b;
      cut = NAME_CHARS;
      for (k = 0; k < NAME_CHARS; k++) begin
        if (nm[8*k +: 8] == SPACE_CHAR) begin
          if (cut > k) cut = k;
        end else begin
          cut = NAME_CHARS;
        end
      end
      nlen = 0;
      while (nlen < cut && nm[8*nlen +: 8] != NUL_CHAR) nlen++;
      elen = 0;
      while (elen < EXT_CHARS && ex[8*elen +: 8] != SPACE_CHAR) elen++;
      total = nlen + elen + ((elen != 0) ? 1 : 0);
      b.len = LEN_W'(total);
      if (total >= int'(cap)) begin
        b.ch = NUL_CHAR;
        b.status = ST_SHORT;
        b.last = 1'b1;
        pending_beats.push_back(b);
        return;
      end
      b.status = ST_OK;
      b.last = 1'b0;
      for (k = 0; k < nlen; k++) begin
        b.ch = nm[8*k +: 8];
        pending_beats.push_back(b);
      end
      if (elen != 0) begin
        b.ch = DOT_CHAR;
        pending_beats.push_back(b);
        for (k = 0; k < elen; k++) begin
          if (ex[8*k +: 8] == NUL_CHAR) break;
          b.ch = ex[8*k +: 8];
          pending_beats.push_back(b);
        end
      end
      b.ch = NUL_CHAR;
      b.last = 1'b1;
      pending_beats.push_back(b);
    endfunction

    function void check_char(name_beat_t got);
      name_beat_t want;
      if (pending_beats.size() == 0) begin
        $error("out_char: expected no beat, got %0h", got.ch);
        mismatches++;
        return;
      end
      want = pending_beats.pop_front();
      if (got.ch !== want.ch) begin
        $error("out_char: expected %0h, got %0h", want.ch, got.ch);
        mismatches++;
      end
      if (got.len !== want.len) begin
        $error("out_name_length: expected %0d, got %0d", want.len, got.len);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("out_status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("out_last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    endfunction

    function int backlog();
      return pending_beats.size();
    endfunction
  endclass

endpackage

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import fsnf_pkg::*;
  import fsnf_tb_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_PER_PHASE = 100;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [NAME_W-1:0] in_name_chars = '0;
  logic [EXT_W-1:0]  in_ext_chars = '0;
  logic [CAP_W-1:0]  in_buffer_size = '0;
  logic              out_valid;
  logic [CHAR_W-1:0] out_char;
  logic [LEN_W-1:0]  out_name_length;
  logic              out_status;
  logic              out_last;

  dotted_name_board board;
  int               stall_cycles;

  fat_short_name_formatter u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_name_chars   (in_name_chars),
    .in_ext_chars    (in_ext_chars),
    .in_buffer_size  (in_buffer_size),
    .out_valid       (out_valid),
    .out_char        (out_char),
    .out_name_length (out_name_length),
    .out_status      (out_status),
    .out_last        (out_last)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else begin
      if (start && !busy) board.note_name(in_name_chars, in_ext_chars, in_buffer_size);
      if (out_valid) board.check_char({out_char, out_name_length, out_status, out_last});
      if ((start && !busy) || out_valid) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic logic [NAME_W-1:0] name8(logic [NAME_W-1:0] s);
    logic [NAME_W-1:0] r;
    int                k;
    for (k = 0; k < 8; k++) r[8*k +: 8] = s[8*(7-k) +: 8];
    return r;
  endfunction

  function automatic logic [EXT_W-1:0] ext3(logic [EXT_W-1:0] s);
    logic [EXT_W-1:0] r;
    int               k;
    for (k = 0; k < 3; k++) r[8*k +: 8] = s[8*(2-k) +: 8];
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] rand_glyph();
    if ($urandom_range(19) == 0) return CHAR_W'($urandom);
    return CHAR_W'($urandom_range(8'h21, 8'h7e));
  endfunction

  function automatic logic [NAME_W-1:0] rand_name();
    logic [NAME_W-1:0] w;
    int                len;
    int                k;
    if ($urandom_range(9) == 0) return {$urandom, $urandom};
    len = $urandom_range(0, 8);
    for (k = 0; k < 8; k++) w[8*k +: 8] = (k < len) ? rand_glyph() : SPACE_CHAR;
    if ($urandom_range(7) == 0)
      w[8*$urandom_range(0, 7) +: 8] = $urandom_range(1) ? NUL_CHAR : SPACE_CHAR;
    return w;
  endfunction

  function automatic logic [EXT_W-1:0] rand_ext();
    logic [EXT_W-1:0] w;
    int               len;
    int               k;
    if ($urandom_range(9) == 0) return EXT_W'($urandom);
    len = $urandom_range(0, 3);
    for (k = 0; k < 3; k++) w[8*k +: 8] = (k < len) ? rand_glyph() : SPACE_CHAR;
    if ($urandom_range(7) == 0)
      w[8*$urandom_range(0, 2) +: 8] = $urandom_range(1) ? NUL_CHAR : SPACE_CHAR;
    return w;
  endfunction

  function automatic logic [CAP_W-1:0] rand_cap();
    case ($urandom_range(9))
      0: return CAP_W'($urandom);
      1, 2, 3: return CAP_W'($urandom_range(0, 8));
      default: return CAP_W'($urandom_range(9, 16));
    endcase
  endfunction

  task automatic idle_gap(input int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  task automatic send_name(input logic [NAME_W-1:0] nm, input logic [EXT_W-1:0] ex,
                           input logic [CAP_W-1:0] cap, input int pct);
    idle_gap(pct);
    start <= 1'b1;
    in_name_chars <= nm;
    in_ext_chars <= ex;
    in_buffer_size <= cap;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_names();
    start <= 1'b0;
    @(posedge clk);
    while (board.backlog() != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int pct);
    int i;
    for (i = 0; i < RANDOM_PER_PHASE; i++) begin
      send_name(rand_name(), rand_ext(), rand_cap(), pct);
      if ($urandom_range(49) == 0) drain_names();
    end
  endtask

  initial begin
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_name(name8("FOO     "), ext3("TXT"), 8'd255, 20);
    send_name(name8("ABCDEFGH"), ext3("XYZ"), 8'd13, 20);
    send_name(name8("ABCDEFGH"), ext3("XYZ"), 8'd12, 20);
    send_name(name8("ABCDEFGH"), ext3("XYZ"), 8'd0, 20);
    send_name(name8("        "), ext3("TXT"), 8'd5, 20);
    send_name(name8("        "), ext3("   "), 8'd1, 20);
    send_name(name8("        "), ext3("   "), 8'd0, 20);
    send_name(64'h2020_2044_4300_4241, ext3("C  "), 8'd20, 20);
    send_name(name8("A B     "), ext3("   "), 8'd10, 20);
    send_name(name8("  X     "), ext3("Z  "), 8'd10, 20);
    send_name(name8("       X"), ext3("Z  "), 8'd11, 20);
    send_name(name8("READ    "), 24'h58_00_54, 8'd9, 20);
    send_name(name8("READ    "), ext3(" AB"), 8'd9, 20);
    send_name(name8("READ    "), ext3("A B"), 8'd9, 20);
    send_name({NAME_W{1'b1}}, {EXT_W{1'b1}}, 8'd255, 20);
    send_name('0, '0, 8'd255, 20);
    send_name('0, '0, 8'd4, 20);
    send_name(name8("X       "), ext3("Y  "), 8'd4, 0);
    send_name(name8("X       "), ext3("Y  "), 8'd3, 0);
    send_name(64'h2020_2020_2020_2000, ext3("DAT"), 8'd5, 0);
    send_name(name8("ab_12~!#"), ext3("e~1"), 8'd200, 0);
    drain_names();

    random_phase(20);
    random_phase(85);
    random_phase(0);

    drain_names();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.backlog() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/fsnf_pkg.sv
src/fsnf_lane.sv
src/fsnf_merge.sv
src/fsnf_emit.sv
src/fat_short_name_formatter.sv
verif/fsnf_tb_pkg.sv
verif/tb_top.sv
